@@ hdl/keyed_record_table_assert.svh @@
// Assertion macros for the keyed record table checker
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// same-cycle implication, gated by reset
`define KRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed_record_table check failed");

// next-cycle implication, gated by reset
`define KRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_record_table check failed");

`endif

@@ hdl/krt_pkg.sv @@
// Shared types and codes of the keyed record table
package krt_pkg;

  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 10;
  localparam int REC_W    = 72;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_MISS  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_LONG  = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SLOT, S_CHK, S_CMP, S_CMPW, S_REC, S_WR, S_CPR, S_CPW
  } state_t;

  typedef struct packed {
    logic [26:0] student_id;
    logic [6:0]  area_code;
    logic [29:0] phone_number;
    logic [7:0]  phone_kind;
  } rec_t;

endpackage

@@ hdl/keyed_record_table.sv @@
// Keyed record table: request in one name byte at a time; the byte marked last runs
// insert, remove or lookup. Full, empty and name-too-long answers come out in the
// cycle after the request. Otherwise a sequencer walks the slots through one memory
// read port: S_SLOT and S_CHK per slot, plus S_CMP and S_CMPW per byte compared on
// slots whose stored length matches, up to the first match (remove, lookup,
// duplicate) or the last slot. Lookup then reads the record; insert writes the slot
// and copies the name a byte at a time. busy is high during the walk. After reset a
// clearing pass frees every slot while busy is high. Results are strobed by out_valid
// for one cycle, the cycle after the last state; the receiver cannot hold them off.
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int ENTRIES  = 1024,
  parameter int NAME_LEN = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_name_char,
  input  logic                in_name_last,
  input  logic [26:0]         in_student_id,
  input  logic [6:0]          in_area_code,
  input  logic [29:0]         in_phone_number,
  input  logic [7:0]          in_phone_kind,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot_index,
  output logic [26:0]         out_found_student_id,
  output logic [6:0]          out_found_area_code,
  output logic [29:0]         out_found_phone_number,
  output logic [7:0]          out_found_phone_kind
);
  localparam int SW = $clog2(ENTRIES);
  localparam int BW = $clog2(NAME_LEN);
  localparam int KW = $clog2(NAME_LEN + 1);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NDEPTH = ENTRIES * (2 ** BW);

  state_t          state_r, state_nxt;
  logic [SW-1:0]   clr_r, clr_nxt;
  logic [KW-1:0]   klen_r, klen_nxt, klen_inc;
  logic [BW-1:0]   len_r, len_nxt;
  logic [1:0]      op_r, op_nxt;
  rec_t            rec_r, rec_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [SW-1:0]   free_r, free_nxt;
  logic            have_free_r, have_free_nxt;
  logic [BW-1:0]   j_r, j_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic            ov_r, ov_nxt;
  logic [STATUS_W-1:0] os_r, os_nxt;
  logic [SW-1:0]   oslot_r, oslot_nxt;
  rec_t            orec_r, orec_nxt;
  logic [SW+SLOT_W-1:0] slot_ext;

  logic            occ_we, occ_wd, occ_q;
  logic [SW-1:0]   occ_wa;
  logic            meta_we;
  logic [BW-1:0]   len_q;
  rec_t            rec_q;
  logic            kb_we;
  logic [7:0]      key_q, name_q;
  logic            name_we;
  logic            adv;
  logic            accept;

  krt_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_occ (
    .clk, .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(slot_r), .rdata(occ_q)
  );
  krt_ram #(.WIDTH(BW), .DEPTH(ENTRIES)) u_len (
    .clk, .we(meta_we), .waddr(free_r), .wdata(len_r), .raddr(slot_r), .rdata(len_q)
  );
  krt_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_rec (
    .clk, .we(meta_we), .waddr(free_r), .wdata(rec_r), .raddr(slot_r), .rdata(rec_q)
  );
  krt_ram #(.WIDTH(8), .DEPTH(NAME_LEN)) u_key (
    .clk, .we(kb_we), .waddr(klen_r[BW-1:0]), .wdata(in_name_char),
    .raddr(j_r), .rdata(key_q)
  );
  krt_ram #(.WIDTH(8), .DEPTH(NDEPTH)) u_name (
    .clk, .we(name_we), .waddr({free_r, j_r}), .wdata(key_q),
    .raddr({slot_r, j_r}), .rdata(name_q)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && (state_r == S_IDLE);
  assign kb_we  = accept && (klen_r < KW'(NAME_LEN - 1));
  assign klen_inc = (klen_r < KW'(NAME_LEN)) ? klen_r + KW'(1) : klen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      klen_r      <= '0;
      cnt_r       <= '0;
      have_free_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      klen_r      <= klen_nxt;
      cnt_r       <= cnt_nxt;
      have_free_r <= have_free_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    op_r    <= op_nxt;
    rec_r   <= rec_nxt;
    slot_r  <= slot_nxt;
    free_r  <= free_nxt;
    j_r     <= j_nxt;
    os_r    <= os_nxt;
    oslot_r <= oslot_nxt;
    orec_r  <= orec_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    klen_nxt      = klen_r;
    len_nxt       = len_r;
    op_nxt        = op_r;
    rec_nxt       = rec_r;
    slot_nxt      = slot_r;
    free_nxt      = free_r;
    have_free_nxt = have_free_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    ov_nxt        = 1'b0;
    os_nxt        = STAT_OK;
    oslot_nxt     = '0;
    orec_nxt      = '0;
    occ_we        = 1'b0;
    occ_wa        = slot_r;
    occ_wd        = 1'b0;
    meta_we       = 1'b0;
    name_we       = 1'b0;
    adv           = 1'b0;

    case (state_r)
      S_CLEAR: begin
        occ_we = 1'b1;
        occ_wa = clr_r;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          klen_nxt = klen_inc;
          if (in_name_last) begin
            klen_nxt      = '0;
            len_nxt       = klen_inc[BW-1:0];
            op_nxt        = in_operation;
            rec_nxt       = '{in_student_id, in_area_code, in_phone_number, in_phone_kind};
            slot_nxt      = '0;
            have_free_nxt = 1'b0;
            if (in_operation == OP_INSERT) begin
              if (cnt_r == CW'(ENTRIES)) begin
                ov_nxt = 1'b1;
                os_nxt = STAT_FULL;
              end else if (klen_inc > KW'(NAME_LEN - 1)) begin
                ov_nxt = 1'b1;
                os_nxt = STAT_LONG;
              end else begin
                state_nxt = S_SLOT;
              end
            end else begin
              if (cnt_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = STAT_EMPTY;
              end else if (klen_inc > KW'(NAME_LEN - 1)) begin
                ov_nxt = 1'b1;
                os_nxt = STAT_LONG;
              end else begin
                state_nxt = S_SLOT;
              end
            end
          end
        end
      end
      S_SLOT: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (occ_q && (len_q == len_r)) begin
          j_nxt     = '0;
          state_nxt = S_CMP;
        end else begin
          if (!occ_q && !have_free_r) begin
            free_nxt      = slot_r;
            have_free_nxt = 1'b1;
          end
          adv = 1'b1;
        end
      end
      S_CMP: begin
        state_nxt = S_CMPW;
      end
      S_CMPW: begin
        if (name_q != key_q) begin
          adv = 1'b1;
        end else if (j_r == len_r - BW'(1)) begin
          case (op_r)
            OP_INSERT: begin
              ov_nxt    = 1'b1;
              os_nxt    = STAT_DUP;
              state_nxt = S_IDLE;
            end
            OP_REMOVE: begin
              occ_we    = 1'b1;
              occ_wa    = slot_r;
              occ_wd    = 1'b0;
              cnt_nxt   = cnt_r - CW'(1);
              ov_nxt    = 1'b1;
              oslot_nxt = slot_r;
              state_nxt = S_IDLE;
            end
            default: begin
              state_nxt = S_REC;
            end
          endcase
        end else begin
          j_nxt     = j_r + BW'(1);
          state_nxt = S_CMP;
        end
      end
      S_REC: begin
        ov_nxt    = 1'b1;
        oslot_nxt = slot_r;
        orec_nxt  = rec_q;
        state_nxt = S_IDLE;
      end
      S_WR: begin
        meta_we   = 1'b1;
        occ_we    = 1'b1;
        occ_wa    = free_r;
        occ_wd    = 1'b1;
        cnt_nxt   = cnt_r + CW'(1);
        j_nxt     = '0;
        state_nxt = S_CPR;
      end
      S_CPR: begin
        state_nxt = S_CPW;
      end
      S_CPW: begin
        name_we = 1'b1;
        if (j_r == len_r - BW'(1)) begin
          ov_nxt    = 1'b1;
          oslot_nxt = free_r;
          state_nxt = S_IDLE;
        end else begin
          j_nxt     = j_r + BW'(1);
          state_nxt = S_CPR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      if (slot_r == SW'(ENTRIES - 1)) begin
        if (op_r == OP_INSERT) begin
          state_nxt = S_WR;
        end else begin
          ov_nxt    = 1'b1;
          os_nxt    = STAT_MISS;
          state_nxt = S_IDLE;
        end
      end else begin
        slot_nxt  = slot_r + SW'(1);
        state_nxt = S_SLOT;
      end
    end
  end

  assign slot_ext               = {{SLOT_W{1'b0}}, oslot_r};
  assign out_valid              = ov_r;
  assign out_status             = os_r;
  assign out_slot_index         = slot_ext[SLOT_W-1:0];
  assign out_found_student_id   = orec_r.student_id;
  assign out_found_area_code    = orec_r.area_code;
  assign out_found_phone_number = orec_r.phone_number;
  assign out_found_phone_kind   = orec_r.phone_kind;
endmodule

@@ hdl/krt_ram.sv @@
// Generic simple dual-port RAM with registered read
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/krt_checker.sv @@
// Port-level checker for the keyed record table, bound to the top level
`include "keyed_record_table_assert.svh"

module krt_assert_checker
  import krt_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                in_name_last,
  input logic                out_valid,
  input logic [STATUS_W-1:0] out_status,
  input logic [SLOT_W-1:0]   out_slot_index,
  input logic [26:0]         out_found_student_id,
  input logic [6:0]          out_found_area_code,
  input logic [29:0]         out_found_phone_number,
  input logic [7:0]          out_found_phone_kind
);
  logic [REC_W-1:0] found_all;

  assign found_all = {out_found_student_id, out_found_area_code, out_found_phone_number,
                      out_found_phone_kind};

  `KRT_ASSERT_NOW(a_status_code, out_valid, out_status <= STAT_LONG)
  `KRT_ASSERT_NOW(a_fail_slot_zero, out_valid && out_status != STAT_OK, out_slot_index == '0)
  `KRT_ASSERT_NOW(a_fail_rec_zero, out_valid && out_status != STAT_OK, found_all == '0)
  `KRT_ASSERT_NEXT(a_no_result_mid_name, start && !busy && !in_name_last, !out_valid)
  `KRT_ASSERT_NEXT(a_busy_no_fast_result, busy && $past(busy), !out_valid || !busy)
endmodule

bind keyed_record_table krt_assert_checker u_krt_checker (.*);

@@ tb/sv/krt_checker.sv @@
// Checker for keyed_record_table: predicts each result from the accepted requests and compares
module krt_checker
  import krt_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int NAME_LEN = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_name_char,
  input  logic                in_name_last,
  input  logic [26:0]         in_student_id,
  input  logic [6:0]          in_area_code,
  input  logic [29:0]         in_phone_number,
  input  logic [7:0]          in_phone_kind,
  input  logic                out_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [SLOT_W-1:0]   out_slot_index,
  input  logic [26:0]         out_found_student_id,
  input  logic [6:0]          out_found_area_code,
  input  logic [29:0]         out_found_phone_number,
  input  logic [7:0]          out_found_phone_kind,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    rec_t                rec;
  } answer_t;

  logic       occupied [ENTRIES];
  logic [7:0] stored_name [ENTRIES][NAME_LEN];
  int         stored_len [ENTRIES];
  rec_t       stored_rec [ENTRIES];
  logic [7:0] key_bytes [NAME_LEN];
  int         key_len;
  answer_t    expected_answers [$];

  assign pending = expected_answers.size();

  function automatic int match_slot();
    for (int i = 0; i < ENTRIES; i++) begin
      if (occupied[i] && stored_len[i] == key_len) begin
        automatic bit same = 1;
        for (int j = 0; j < key_len; j++)
          if (stored_name[i][j] != key_bytes[j]) same = 0;
        if (same) return i;
      end
    end
    return -1;
  endfunction

  function automatic answer_t table_operation(rec_t rec_in);
    answer_t a;
    int free_slot;
    int hit;
    bit any;
    a = '0;
    if (in_operation == OP_INSERT) begin
      free_slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (!occupied[i]) free_slot = i;
      if (free_slot < 0) a.status = STAT_FULL;
      else if (key_len > NAME_LEN - 1) a.status = STAT_LONG;
      else if (match_slot() >= 0) a.status = STAT_DUP;
      else begin
        for (int j = 0; j < key_len; j++) stored_name[free_slot][j] = key_bytes[j];
        stored_len[free_slot] = key_len;
        stored_rec[free_slot] = rec_in;
        occupied[free_slot] = 1'b1;
        a.status = STAT_OK;
        a.slot = free_slot[SLOT_W-1:0];
      end
    end else begin
      any = 0;
      for (int i = 0; i < ENTRIES; i++) if (occupied[i]) any = 1;
      if (!any) a.status = STAT_EMPTY;
      else if (key_len > NAME_LEN - 1) a.status = STAT_LONG;
      else begin
        hit = match_slot();
        if (hit < 0) a.status = STAT_MISS;
        else begin
          a.status = STAT_OK;
          a.slot = hit[SLOT_W-1:0];
          if (in_operation == OP_REMOVE) occupied[hit] = 1'b0;
          else a.rec = stored_rec[hit];
        end
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    rec_t    got_rec;
    if (!rst_n) begin
      fail_count <= 0;
      key_len = 0;
      expected_answers.delete();
      for (int i = 0; i < ENTRIES; i++) occupied[i] = 1'b0;
    end else begin
      if (out_valid) begin
        got_rec = {out_found_student_id, out_found_area_code, out_found_phone_number,
                   out_found_phone_kind};
        if (expected_answers.size() == 0) begin
          $display("%0t: result with no request waiting, status %0d", $time, out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_answers.pop_front();
          if (want.status !== out_status || want.slot !== out_slot_index ||
              want.rec !== got_rec) begin
            $display("%0t: status exp %0d got %0d, slot exp %0d got %0d", $time,
                     want.status, out_status, want.slot, out_slot_index);
            $display("%0t: record exp %h_%h_%h_%h got %h_%h_%h_%h", $time,
                     want.rec.student_id, want.rec.area_code, want.rec.phone_number,
                     want.rec.phone_kind, got_rec.student_id, got_rec.area_code,
                     got_rec.phone_number, got_rec.phone_kind);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (key_len < NAME_LEN - 1) key_bytes[key_len] = in_name_char;
        if (key_len < NAME_LEN) key_len++;
        if (in_name_last) begin
          expected_answers.push_back(table_operation({in_student_id, in_area_code,
                                                      in_phone_number, in_phone_kind}));
          key_len = 0;
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
// Top of the keyed_record_table testbench: clock, reset, name requests and verdict
module tb_top;
  import krt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES  = 16;
  localparam int NAME_LEN = 128;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam int POOL = 24;
  localparam int STALL_LIMIT = 30000;

  logic clk, rst_n, start, busy;
  logic [1:0]  in_operation;
  logic [7:0]  in_name_char, in_phone_kind;
  logic        in_name_last;
  logic [26:0] in_student_id;
  logic [6:0]  in_area_code;
  logic [29:0] in_phone_number;
  logic        out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot_index;
  logic [26:0] out_found_student_id;
  logic [6:0]  out_found_area_code;
  logic [29:0] out_found_phone_number;
  logic [7:0]  out_found_phone_kind;
  int fail_count, pending;

  logic [7:0] name_pool [POOL][200];
  int         pool_len [POOL];
  int         items_sent;
  int         burst_left;
  int         idle_cycles;

  keyed_record_table #(.ENTRIES(ENTRIES), .NAME_LEN(NAME_LEN)) dut (.*);
  krt_checker #(.ENTRIES(ENTRIES), .NAME_LEN(NAME_LEN)) chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // one byte request; random gaps between bursts
  task automatic send_byte(input logic [1:0] op, input logic [7:0] ch, input logic last,
                           input logic [26:0] sid, input logic [6:0] area,
                           input logic [29:0] phone, input logic [7:0] kind);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start = 1'b1;
    in_operation = op;
    in_name_char = ch;
    in_name_last = last;
    in_student_id = sid;
    in_area_code = area;
    in_phone_number = phone;
    in_phone_kind = kind;
    while (busy) @(negedge clk);
    @(posedge clk);
    items_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_name(input logic [1:0] op, input int idx, input bit extreme);
    logic [26:0] sid;
    logic [6:0]  area;
    logic [29:0] phone;
    logic [7:0]  kind;
    for (int i = 0; i < pool_len[idx]; i++) begin
      sid = $urandom; area = $urandom; phone = $urandom; kind = $urandom;
      if (extreme) begin
        sid = '1; area = '1; phone = '1; kind = '1;
      end
      send_byte(op, pool_byte(idx, i), i == pool_len[idx] - 1, sid, area, phone, kind);
    end
  endtask

  function automatic logic [7:0] pool_byte(int i, int j);
    return name_pool[i][j];
  endfunction

  initial begin
    logic [1:0] op;
    int pick;
    start = 1'b0; rst_n = 1'b0;
    in_operation = OP_INSERT; in_name_char = '0; in_name_last = 1'b0;
    in_student_id = '0; in_area_code = '0; in_phone_number = '0; in_phone_kind = '0;
    items_sent = 0; burst_left = 0;
    for (int i = 0; i < POOL; i++) begin
      pool_len[i] = $urandom_range(1, 5);
      for (int j = 0; j < 200; j++) name_pool[i][j] = $urandom_range(0, 255);
    end
    pool_len[1] = pool_len[0] + 1;
    for (int j = 0; j < pool_len[0]; j++) name_pool[1][j] = name_pool[0][j];
    pool_len[2] = 1; name_pool[2][0] = 8'h00;
    pool_len[3] = 1; name_pool[3][0] = 8'hFF;
    pool_len[4] = NAME_LEN - 1;
    pool_len[5] = NAME_LEN;
    pool_len[6] = 200;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, insert, duplicate, hits, miss, spare op, long names
    send_name(OP_LOOKUP, 0, 0);
    send_name(OP_REMOVE, 0, 0);
    send_name(OP_INSERT, 0, 1);
    send_name(OP_INSERT, 0, 0);
    send_name(OP_INSERT, 2, 0);
    send_name(OP_LOOKUP, 2, 0);
    send_name(OP_LOOKUP, 1, 0);
    send_name(OP_SPARE, 0, 0);
    send_name(OP_REMOVE, 0, 0);
    send_name(OP_INSERT, 3, 1);
    send_name(OP_LOOKUP, 3, 0);
    send_name(OP_INSERT, 5, 0);
    send_name(OP_LOOKUP, 6, 0);

    // random: alternate fill-heavy and drain-heavy phases
    while (items_sent < 580) begin
      pick = $urandom_range(0, 99);
      if (((items_sent / 150) % 2) == 0)
        op = pick < 70 ? OP_INSERT : pick < 80 ? OP_REMOVE : pick < 95 ? OP_LOOKUP : OP_SPARE;
      else
        op = pick < 15 ? OP_INSERT : pick < 60 ? OP_REMOVE : pick < 95 ? OP_LOOKUP : OP_SPARE;
      pick = $urandom_range(0, 19) == 0 ? $urandom_range(4, 6) : $urandom_range(0, POOL - 1);
      if (pick >= 4 && pick <= 6 && $urandom_range(0, 3) != 0) pick = 7;
      send_name(op, pick, $urandom_range(0, 15) == 0);
    end

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
